>>> rtl/core/assert_macros.svh
// Assertion helper macros shared by the RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent property check with a message.
`define ASSERT_PROP(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Implication check: when cond holds, expr must hold in the next cycle.
`define ASSERT_NEXT(lbl, cond, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond) |=> (expr)) \
		else $error(msg);

`endif

>>> rtl/core/pvr_pkg.sv
// Package for the pixel value replace block: widths, register indexes and
// the item type that travels from the front end to the divider back end.
`timescale 1ns / 1ps

package pvr_pkg;

	localparam int CHAN_W  = 8;
	localparam int PROD_W  = 2 * CHAN_W;
	localparam int PIX_W   = 4 * CHAN_W;
	localparam int LEVEL_W = 9;
	localparam int CFG_IDX_W = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_MODE_RELATIVE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LEVEL         = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ALPHA    = 2'd2;

	localparam logic [CHAN_W-1:0] CHAN_FULL = 8'hFF;

	// One classified pixel: target times each channel, plus max, target and alpha.
	typedef struct packed {
		logic [PROD_W-1:0] prod_r;
		logic [PROD_W-1:0] prod_g;
		logic [PROD_W-1:0] prod_b;
		logic [CHAN_W-1:0] mx;
		logic [CHAN_W-1:0] tgt;
		logic [CHAN_W-1:0] alpha;
	} pvr_item_t;

endpackage

>>> rtl/core/pvr_front.sv
// Front end: configuration registers, pixel accept, max/target/alpha
// classification and the three target*channel products. Uses pvr_pkg.
`timescale 1ns / 1ps

module pvr_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pvr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pvr_pkg::LEVEL_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pvr_pkg::PIX_W-1:0]     s_tdata,
	output logic                          out_valid,
	input  logic                          out_ready,
	output pvr_pkg::pvr_item_t            out_item
);
	import pvr_pkg::*;

	logic                      mode_q;
	logic signed [LEVEL_W-1:0] level_q;
	logic                      keep_q;

	logic              vld_s1;
	logic [CHAN_W-1:0] r_s1, g_s1, b_s1, a_s1, mx_s1, tgt_s1;
	logic              vld_s2;
	pvr_item_t         item_s2;

	logic              en_s2, en_s1;
	logic [CHAN_W-1:0] in_a, in_r, in_g, in_b, mx_c, tgt_c;
	logic signed [LEVEL_W:0] sum_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= 1'b0;
			level_q <= 9'sd255;
			keep_q  <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_MODE_RELATIVE: mode_q  <= cfg_data[0];
				CFG_LEVEL:         level_q <= cfg_data;
				CFG_KEEP_ALPHA:    keep_q  <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign en_s2    = !vld_s2 || out_ready;
	assign en_s1    = !vld_s1 || en_s2;
	assign s_tready = en_s1;

	assign in_a = s_tdata[31:24];
	assign in_r = s_tdata[23:16];
	assign in_g = s_tdata[15:8];
	assign in_b = s_tdata[7:0];

	always_comb begin
		mx_c = in_r;
		if (in_g > mx_c) mx_c = in_g;
		if (in_b > mx_c) mx_c = in_b;
		if (mode_q)
			sum_c = $signed({2'b00, mx_c}) + $signed({level_q[LEVEL_W-1], level_q});
		else
			sum_c = $signed({level_q[LEVEL_W-1], level_q});
		// clamp target to one channel's range
		if (sum_c < 0)
			tgt_c = '0;
		else if (sum_c > $signed({2'b00, CHAN_FULL}))
			tgt_c = CHAN_FULL;
		else
			tgt_c = sum_c[CHAN_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (en_s1) vld_s1 <= s_tvalid;
			if (en_s2) vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			r_s1   <= in_r;
			g_s1   <= in_g;
			b_s1   <= in_b;
			a_s1   <= keep_q ? in_a : CHAN_FULL;
			mx_s1  <= mx_c;
			tgt_s1 <= tgt_c;
		end
		if (en_s2) begin
			item_s2.prod_r <= PROD_W'(tgt_s1) * PROD_W'(r_s1);
			item_s2.prod_g <= PROD_W'(tgt_s1) * PROD_W'(g_s1);
			item_s2.prod_b <= PROD_W'(tgt_s1) * PROD_W'(b_s1);
			item_s2.mx     <= mx_s1;
			item_s2.tgt    <= tgt_s1;
			item_s2.alpha  <= a_s1;
		end
	end

	assign out_valid = vld_s2;
	assign out_item  = item_s2;

endmodule

>>> rtl/core/pvr_fifo.sv
// Short queue between front end and divider back end.
// Register-based, DEPTH entries of pvr_item_t. Uses pvr_pkg, assert_macros.svh.
`timescale 1ns / 1ps

module pvr_fifo #(
	parameter int DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  pvr_pkg::pvr_item_t in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output pvr_pkg::pvr_item_t out_item
);
	import pvr_pkg::*;
	`include "assert_macros.svh"

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	pvr_item_t        mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign in_ready  = (cnt_q != CNT_FULL);
	assign out_valid = (cnt_q != '0);
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;
	assign out_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	`ASSERT_PROP(a_cnt_range, cnt_q <= CNT_FULL, "queue count above depth")
	`ASSERT_PROP(a_full_ptrs, (cnt_q != CNT_FULL) || (wr_ptr_q == rd_ptr_q), "full ptrs apart")
	`ASSERT_NEXT(a_cnt_inc, push && !pop, cnt_q == $past(cnt_q) + 1'b1, "count missed a push")
	`ASSERT_NEXT(a_cnt_dec, pop && !push, cnt_q == $past(cnt_q) - 1'b1, "count missed a pop")

endmodule

>>> rtl/core/pvr_back.sv
// Back end: restoring divider pipeline, one quotient bit per stage for each
// channel, then the output register. Uses pvr_pkg.
`timescale 1ns / 1ps

module pvr_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_ready,
	input  pvr_pkg::pvr_item_t        in_item,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [pvr_pkg::PIX_W-1:0] m_tdata
);
	import pvr_pkg::*;

	localparam int NSTEP = CHAN_W;

	typedef struct packed {
		logic [PROD_W-1:0] rem_r;
		logic [PROD_W-1:0] rem_g;
		logic [PROD_W-1:0] rem_b;
		logic [CHAN_W-1:0] q_r;
		logic [CHAN_W-1:0] q_g;
		logic [CHAN_W-1:0] q_b;
		logic [CHAN_W-1:0] mx;
		logic [CHAN_W-1:0] tgt;
		logic [CHAN_W-1:0] alpha;
	} pvr_div_t;

	pvr_div_t           div_s [NSTEP+1];
	pvr_div_t           div_nxt [NSTEP];
	logic [NSTEP:0]     vld_s;
	logic               out_vld_q;
	logic [PIX_W-1:0]   pix_q;
	logic               en;
	logic [CHAN_W-1:0]  res_r, res_g, res_b;

	// one restoring step: {quotient bit, new remainder}
	function automatic logic [PROD_W:0] div_bit(input logic [PROD_W-1:0] rem,
	                                             input logic [PROD_W-1:0] dv);
		logic [PROD_W:0] res;
		if (rem >= dv) res = {1'b1, rem - dv};
		else           res = {1'b0, rem};
		return res;
	endfunction

	assign en       = !out_vld_q || m_tready;
	assign in_ready = en;

	for (genvar k = 0; k < NSTEP; k++) begin : g_step
		localparam int SH = NSTEP - 1 - k;
		logic [PROD_W-1:0] dv;
		logic [PROD_W:0]   st_r, st_g, st_b;
		assign dv   = {{(PROD_W-CHAN_W){1'b0}}, div_s[k].mx} << SH;
		assign st_r = div_bit(div_s[k].rem_r, dv);
		assign st_g = div_bit(div_s[k].rem_g, dv);
		assign st_b = div_bit(div_s[k].rem_b, dv);
		always_comb begin
			div_nxt[k]        = div_s[k];
			div_nxt[k].rem_r  = st_r[PROD_W-1:0];
			div_nxt[k].rem_g  = st_g[PROD_W-1:0];
			div_nxt[k].rem_b  = st_b[PROD_W-1:0];
			div_nxt[k].q_r[SH] = st_r[PROD_W];
			div_nxt[k].q_g[SH] = st_g[PROD_W];
			div_nxt[k].q_b[SH] = st_b[PROD_W];
		end
		always_ff @(posedge clk) begin
			if (en) div_s[k+1] <= div_nxt[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_s[0].rem_r <= in_item.prod_r;
			div_s[0].rem_g <= in_item.prod_g;
			div_s[0].rem_b <= in_item.prod_b;
			div_s[0].q_r   <= '0;
			div_s[0].q_g   <= '0;
			div_s[0].q_b   <= '0;
			div_s[0].mx    <= in_item.mx;
			div_s[0].tgt   <= in_item.tgt;
			div_s[0].alpha <= in_item.alpha;
			pix_q          <= {div_s[NSTEP].alpha, res_r, res_g, res_b};
		end
	end

	// black pixel: every channel takes the target
	assign res_r = (div_s[NSTEP].mx == '0) ? div_s[NSTEP].tgt : div_s[NSTEP].q_r;
	assign res_g = (div_s[NSTEP].mx == '0) ? div_s[NSTEP].tgt : div_s[NSTEP].q_g;
	assign res_b = (div_s[NSTEP].mx == '0) ? div_s[NSTEP].tgt : div_s[NSTEP].q_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			out_vld_q <= 1'b0;
		end else if (en) begin
			vld_s     <= {vld_s[NSTEP-1:0], in_valid};
			out_vld_q <= vld_s[NSTEP];
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = pix_q;

endmodule

>>> rtl/core/pixel_value_replace.sv
// Pipeline from input beat to output beat: two front stages, queue, divider input
// and eight divider stages, output register.
// Throughput: one pixel per cycle while m_tready stays high; the back end moves as one pipeline on m_tready.
// Reset: arst_n clears all valid state and queue; config returns to absolute
// mode, level 255, keep alpha.
`timescale 1ns / 1ps

module pixel_value_replace #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pvr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pvr_pkg::LEVEL_W-1:0]   cfg_data,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pvr_pkg::PIX_W-1:0]     s_tdata,  // pixel_in [31:0]
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pvr_pkg::PIX_W-1:0]     m_tdata   // pixel_out [31:0]
);
	import pvr_pkg::*;

	pvr_item_t front_item, back_item;
	logic      front_valid, front_ready, back_valid, back_ready;

	pvr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.out_item  (front_item)
	);

	pvr_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (front_valid),
		.in_ready  (front_ready),
		.in_item   (front_item),
		.out_valid (back_valid),
		.out_ready (back_ready),
		.out_item  (back_item)
	);

	pvr_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (back_valid),
		.in_ready (back_ready),
		.in_item  (back_item),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
